// File: src/pcio_pkg.sv
// Package for the PC I/O port decoder: command codes, port addresses,
// access-mode codes and register masks. No dependencies.
package pcio_pkg;

    typedef enum logic [1:0] {
        CMD_READ   = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_KEY    = 2'd2,
        CMD_UNUSED = 2'd3
    } cmd_t;

    // 8253 access field, bits 5:4 of the mode byte
    typedef enum logic [1:0] {
        ACC_LATCH = 2'd0,
        ACC_LOW   = 2'd1,
        ACC_HIGH  = 2'd2,
        ACC_WORD  = 2'd3
    } acc_t;

    // channel select field, bits 7:6 of the mode byte
    localparam logic [1:0] SEL_CH0 = 2'd0;
    localparam logic [1:0] SEL_CH2 = 2'd2;

    localparam logic [15:0] PORT_TIMER0   = 16'h0040;
    localparam logic [15:0] PORT_TIMER2   = 16'h0042;
    localparam logic [15:0] PORT_MODE     = 16'h0043;
    localparam logic [15:0] PORT_KBD_DATA = 16'h0060;
    localparam logic [15:0] PORT_GATE     = 16'h0061;
    localparam logic [15:0] PORT_KBD_STAT = 16'h0064;
    localparam logic [15:0] PORT_SEQ_IDX  = 16'h03C4;
    localparam logic [15:0] PORT_SEQ_DAT  = 16'h03C5;
    localparam logic [15:0] PORT_GR_IDX   = 16'h03CE;
    localparam logic [15:0] PORT_GR_DAT   = 16'h03CF;
    localparam logic [15:0] PORT_MDA_IDX  = 16'h03B4;
    localparam logic [15:0] PORT_MDA_DAT  = 16'h03B5;
    localparam logic [15:0] PORT_CGA_IDX  = 16'h03D4;
    localparam logic [15:0] PORT_CGA_DAT  = 16'h03D5;
    localparam logic [15:0] PORT_COLOR    = 16'h03D9;
    localparam logic [15:0] PORT_STATUS   = 16'h03DA;

    localparam logic [7:0] CRTC_START_HI = 8'h0C;
    localparam logic [7:0] CRTC_START_LO = 8'h0D;

    localparam int          SEQ_NUM = 5;
    localparam int          GR_NUM  = 9;
    localparam logic [7:0]  VSYNC_BIT = 8'h08;
    localparam logic [7:0]  BYTE_ONES = 8'hFF;

    typedef logic [2:0] seq_idx_t;
    typedef logic [3:0] gr_idx_t;

    function automatic logic [7:0] seq_mask(input seq_idx_t idx);
        logic [7:0] m;
        case (idx)
            3'd0:    m = 8'h03;
            3'd1:    m = 8'h3F;
            3'd2:    m = 8'h0F;
            3'd3:    m = 8'h7F;
            3'd4:    m = 8'h0F;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] gr_mask(input gr_idx_t idx);
        logic [7:0] m;
        case (idx)
            4'd0:    m = 8'h0F;
            4'd1:    m = 8'h0F;
            4'd2:    m = 8'h0F;
            4'd3:    m = 8'h3F;
            4'd4:    m = 8'h03;
            4'd5:    m = 8'h7F;
            4'd6:    m = 8'h0F;
            4'd7:    m = 8'h0F;
            4'd8:    m = 8'hFF;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

endpackage

// File: src/pcio_if.sv
// Channel interfaces of the PC I/O port decoder: request, result and
// configuration. No dependencies.
interface pcio_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [15:0] port_addr;
    logic [7:0]  write_data;
    logic [15:0] timer_now;
    logic [15:0] sound_count;
    logic        vsync;

    modport source (output valid, cmd, port_addr, write_data, timer_now, sound_count, vsync,
                    input ready);
    modport sink   (input valid, cmd, port_addr, write_data, timer_now, sound_count, vsync,
                    output ready);
endinterface

interface pcio_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic        timer_reload;
    logic [15:0] timer_divisor;
    logic        sound_update;
    logic [15:0] sound_divisor;
    logic        counter_load;
    logic [15:0] counter_value;
    logic        gate_update;
    logic [7:0]  speaker_gate;
    logic        key_irq;
    logic [16:0] display_offset;
    logic        text_blink;

    modport source (output valid, read_data, timer_reload, timer_divisor, sound_update,
                    sound_divisor, counter_load, counter_value, gate_update, speaker_gate,
                    key_irq, display_offset, text_blink,
                    input ready);
    modport sink   (input valid, read_data, timer_reload, timer_divisor, sound_update,
                    sound_divisor, counter_load, counter_value, gate_update, speaker_gate,
                    key_irq, display_offset, text_blink,
                    output ready);
endinterface

interface pcio_cfg_if;
    logic valid;
    logic ready;
    logic text_mode;

    modport source (output valid, text_mode, input ready);
    modport sink   (input valid, text_mode, output ready);
endinterface

// File: src/pc_io_port_decoder.sv
// PC/XT-style I/O port decoder: 8253 channels 0 and 2, keyboard queue,
// EGA sequencer/graphics, CGA colour select and CRTC start offset.
// Depends on pcio_pkg and the interfaces in pcio_if.sv.
//
//  channel | dir | payload                                   | accepted when
//  --------+-----+-------------------------------------------+----------------
//  req     | in  | cmd, port_addr, write_data, timer_now,     | valid && ready
//          |     | sound_count, vsync                        |
//  rsp     | out | read_data, event flags, divisors, offset  | valid && ready
//  cfg     | in  | text_mode                                 | valid && ready
//
// Request to result: an input register, then one pass of decode logic that
// updates the port state and loads the result register. One item per cycle
// is sustained while rsp.ready holds; the slowest path is the 16-bit port
// compare feeding the state muxes. Reset clears all port state (blink on,
// text mode on). A stalled result holds the decode stage, and a full input
// register then holds req.ready low; ready is never tied to an idle state.
module pc_io_port_decoder #(
    parameter int KEY_DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    pcio_req_if.sink        req,
    pcio_rsp_if.source      rsp,
    pcio_cfg_if.sink        cfg
);

    localparam int KIDX_W = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int CNT_W  = $clog2(KEY_DEPTH + 1);

    // ---------------- handshake ----------------
    logic in_valid_reg;
    logic out_valid_reg;
    logic fire;         // decode stage moves an item into the result register

    assign fire      = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || fire;
    assign cfg.ready = 1'b1;

    // ---------------- input register ----------------
    logic [1:0]  cmd_reg;
    logic [15:0] addr_reg;
    logic [7:0]  data_reg;
    logic [15:0] now_reg;
    logic [15:0] scount_reg;
    logic        vsync_reg;

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            cmd_reg    <= req.cmd;
            addr_reg   <= req.port_addr;
            data_reg   <= req.write_data;
            now_reg    <= req.timer_now;
            scount_reg <= req.sound_count;
            vsync_reg  <= req.vsync;
        end
    end

    // ---------------- port state ----------------
    logic                text_mode_reg;
    logic                t_high_reg,  t_high_next;
    logic [7:0]          t_mode_reg,  t_mode_next;
    logic [15:0]         t_div_reg,   t_div_next;
    logic [15:0]         t_latch_reg, t_latch_next;
    logic                s_high_reg,  s_high_next;
    logic [7:0]          s_mode_reg,  s_mode_next;
    logic [15:0]         s_div_reg,   s_div_next;
    logic [15:0]         s_latch_reg, s_latch_next;
    logic [7:0]          gate_reg,    gate_next;
    logic [7:0]          key_reg   [KEY_DEPTH];
    logic [7:0]          key_next  [KEY_DEPTH];
    logic [CNT_W-1:0]    kcnt_reg,    kcnt_next;
    pcio_pkg::seq_idx_t  seq_idx_reg, seq_idx_next;
    logic [6:0]          seq_reg   [pcio_pkg::SEQ_NUM];
    logic [6:0]          seq_next  [pcio_pkg::SEQ_NUM];
    pcio_pkg::gr_idx_t   gr_idx_reg,  gr_idx_next;
    logic [7:0]          gr_reg    [pcio_pkg::GR_NUM];
    logic [7:0]          gr_next   [pcio_pkg::GR_NUM];
    logic [7:0]          color_reg,   color_next;
    logic [7:0]          crtc_idx_reg, crtc_idx_next;
    logic [16:0]         offset_reg,  offset_next;
    logic                blink_reg,   blink_next;

    // result flags for the item in decode
    logic [7:0] rd;
    logic       t_reload, s_update, c_load, g_update, k_irq;

    pcio_pkg::acc_t t_acc, s_acc;
    assign t_acc = pcio_pkg::acc_t'(t_mode_reg[5:4]);
    assign s_acc = pcio_pkg::acc_t'(s_mode_reg[5:4]);

    always_comb
    begin
        t_high_next   = t_high_reg;
        t_mode_next   = t_mode_reg;
        t_div_next    = t_div_reg;
        t_latch_next  = t_latch_reg;
        s_high_next   = s_high_reg;
        s_mode_next   = s_mode_reg;
        s_div_next    = s_div_reg;
        s_latch_next  = s_latch_reg;
        gate_next     = gate_reg;
        key_next      = key_reg;
        kcnt_next     = kcnt_reg;
        seq_idx_next  = seq_idx_reg;
        seq_next      = seq_reg;
        gr_idx_next   = gr_idx_reg;
        gr_next       = gr_reg;
        color_next    = color_reg;
        crtc_idx_next = crtc_idx_reg;
        offset_next   = offset_reg;
        blink_next    = blink_reg;
        rd            = pcio_pkg::BYTE_ONES;
        t_reload      = 1'b0;
        s_update      = 1'b0;
        c_load        = 1'b0;
        g_update      = 1'b0;
        k_irq         = 1'b0;

        case (cmd_reg)
            pcio_pkg::CMD_READ:
            begin
                unique case (addr_reg) inside
                    pcio_pkg::PORT_TIMER0:
                    begin
                        // low byte snapshots the free-running count
                        if (t_high_reg)
                        begin
                            t_high_next = 1'b0;
                            rd          = t_latch_reg[15:8];
                        end
                        else
                        begin
                            t_latch_next = now_reg;
                            t_high_next  = 1'b1;
                            rd           = now_reg[7:0];
                        end
                    end
                    pcio_pkg::PORT_TIMER2:
                    begin
                        unique case (s_acc)
                            pcio_pkg::ACC_WORD:
                            begin
                                s_high_next = !s_high_reg;
                                rd = s_high_reg ? s_div_reg[15:8] : s_div_reg[7:0];
                            end
                            pcio_pkg::ACC_LOW:  rd = s_div_reg[7:0];
                            pcio_pkg::ACC_HIGH: rd = s_div_reg[15:8];
                            default:
                            begin
                                if (s_high_reg)
                                begin
                                    s_high_next = 1'b0;
                                    rd          = s_latch_reg[15:8];
                                end
                                else
                                begin
                                    s_latch_next = scount_reg;
                                    s_high_next  = 1'b1;
                                    rd           = scount_reg[7:0];
                                end
                            end
                        endcase
                    end
                    pcio_pkg::PORT_MODE:     rd = s_mode_reg;
                    pcio_pkg::PORT_KBD_DATA:
                    begin
                        rd = key_reg[0];
                        if (kcnt_reg > CNT_W'(1))
                        begin
                            for (int i = 0; i < KEY_DEPTH - 1; i++)
                            begin
                                key_next[i] = key_reg[i + 1];
                            end
                            k_irq = 1'b1;
                        end
                        if (kcnt_reg != '0)
                        begin
                            kcnt_next = kcnt_reg - CNT_W'(1);
                        end
                    end
                    pcio_pkg::PORT_GATE:     rd = gate_reg;
                    pcio_pkg::PORT_KBD_STAT: rd = {7'd0, (kcnt_reg != '0)};
                    pcio_pkg::PORT_SEQ_IDX:  rd = {5'd0, seq_idx_reg};
                    pcio_pkg::PORT_SEQ_DAT:
                    begin
                        rd = (seq_idx_reg < 3'(pcio_pkg::SEQ_NUM))
                           ? {1'b0, seq_reg[seq_idx_reg]} : 8'd0;
                    end
                    pcio_pkg::PORT_GR_IDX:   rd = {4'd0, gr_idx_reg};
                    pcio_pkg::PORT_GR_DAT:
                    begin
                        rd = (gr_idx_reg < 4'(pcio_pkg::GR_NUM)) ? gr_reg[gr_idx_reg] : 8'd0;
                    end
                    pcio_pkg::PORT_COLOR:    rd = color_reg;
                    pcio_pkg::PORT_STATUS:   rd = vsync_reg ? pcio_pkg::VSYNC_BIT : 8'd0;
                    default:                 rd = pcio_pkg::BYTE_ONES;
                endcase
            end
            pcio_pkg::CMD_WRITE:
            begin
                unique case (addr_reg) inside
                    pcio_pkg::PORT_TIMER0:
                    begin
                        unique case (t_acc)
                            pcio_pkg::ACC_WORD:
                            begin
                                if (t_high_reg)
                                begin
                                    t_div_next  = {data_reg, t_div_reg[7:0]};
                                    t_high_next = 1'b0;
                                    t_reload    = 1'b1;
                                end
                                else
                                begin
                                    t_div_next  = {t_div_reg[15:8], data_reg};
                                    t_high_next = 1'b1;
                                end
                            end
                            pcio_pkg::ACC_LOW:
                            begin
                                t_div_next = {t_div_reg[15:8], data_reg};
                                t_reload   = 1'b1;
                            end
                            pcio_pkg::ACC_HIGH:
                            begin
                                t_div_next = {data_reg, t_div_reg[7:0]};
                                t_reload   = 1'b1;
                            end
                            default: ;  // latch mode: write dropped
                        endcase
                    end
                    pcio_pkg::PORT_TIMER2:
                    begin
                        unique case (s_acc)
                            pcio_pkg::ACC_WORD:
                            begin
                                if (s_high_reg)
                                begin
                                    s_div_next  = {data_reg, s_div_reg[7:0]};
                                    s_high_next = 1'b0;
                                    s_update    = 1'b1;
                                end
                                else
                                begin
                                    s_div_next  = {s_div_reg[15:8], data_reg};
                                    s_high_next = 1'b1;
                                end
                            end
                            pcio_pkg::ACC_LOW:
                            begin
                                s_div_next = {s_div_reg[15:8], data_reg};
                                s_update   = 1'b1;
                            end
                            pcio_pkg::ACC_HIGH:
                            begin
                                s_div_next = {data_reg, s_div_reg[7:0]};
                                s_update   = 1'b1;
                            end
                            default:
                            begin
                                // latch mode loads the speaker counter
                                if (s_high_reg)
                                begin
                                    s_latch_next = {data_reg, s_latch_reg[7:0]};
                                    s_high_next  = 1'b0;
                                    c_load       = 1'b1;
                                end
                                else
                                begin
                                    s_latch_next = {s_latch_reg[15:8], data_reg};
                                    s_high_next  = 1'b1;
                                end
                            end
                        endcase
                    end
                    pcio_pkg::PORT_MODE:
                    begin
                        if (data_reg[7:6] == pcio_pkg::SEL_CH0)
                        begin
                            t_mode_next = data_reg;
                            t_high_next = 1'b0;
                        end
                        else if (data_reg[7:6] == pcio_pkg::SEL_CH2)
                        begin
                            s_high_next = 1'b0;
                            if (data_reg != s_mode_reg)
                            begin
                                s_mode_next = data_reg;
                                s_update    = 1'b1;
                            end
                        end
                    end
                    pcio_pkg::PORT_GATE:
                    begin
                        gate_next = data_reg;
                        g_update  = 1'b1;
                    end
                    pcio_pkg::PORT_SEQ_IDX:  seq_idx_next = data_reg[2:0];
                    pcio_pkg::PORT_SEQ_DAT:
                    begin
                        if (seq_idx_reg < 3'(pcio_pkg::SEQ_NUM))
                        begin
                            seq_next[seq_idx_reg] =
                                data_reg[6:0] & 7'(pcio_pkg::seq_mask(seq_idx_reg));
                        end
                    end
                    pcio_pkg::PORT_GR_IDX:   gr_idx_next = data_reg[3:0];
                    pcio_pkg::PORT_GR_DAT:
                    begin
                        if (gr_idx_reg < 4'(pcio_pkg::GR_NUM))
                        begin
                            gr_next[gr_idx_reg] = data_reg & pcio_pkg::gr_mask(gr_idx_reg);
                        end
                    end
                    pcio_pkg::PORT_COLOR:
                    begin
                        color_next = data_reg;
                        blink_next = !data_reg[4];
                    end
                    pcio_pkg::PORT_MDA_IDX, pcio_pkg::PORT_CGA_IDX:
                    begin
                        crtc_idx_next = data_reg;
                    end
                    pcio_pkg::PORT_MDA_DAT, pcio_pkg::PORT_CGA_DAT:
                    begin
                        // text modes address words, so the start moves up one bit
                        if (crtc_idx_reg == pcio_pkg::CRTC_START_HI)
                        begin
                            offset_next = text_mode_reg ? {data_reg, offset_reg[8:0]}
                                                        : {1'b0, data_reg, offset_reg[7:0]};
                        end
                        else if (crtc_idx_reg == pcio_pkg::CRTC_START_LO)
                        begin
                            offset_next = text_mode_reg ? {offset_reg[16:9], data_reg, 1'b0}
                                                        : {1'b0, offset_reg[15:8], data_reg};
                        end
                    end
                    default: ;
                endcase
            end
            pcio_pkg::CMD_KEY:
            begin
                // append; dropped when the queue is full
                if (kcnt_reg < CNT_W'(KEY_DEPTH))
                begin
                    if (kcnt_reg == '0)
                    begin
                        k_irq = 1'b1;
                    end
                    key_next[kcnt_reg[KIDX_W-1:0]] = data_reg;
                    kcnt_next = kcnt_reg + CNT_W'(1);
                end
            end
            default: ;  // unused command: no effect
        endcase
    end

    // ---------------- control and state registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            text_mode_reg <= 1'b1;
            t_high_reg    <= 1'b0;
            t_mode_reg    <= '0;
            t_div_reg     <= '0;
            t_latch_reg   <= '0;
            s_high_reg    <= 1'b0;
            s_mode_reg    <= '0;
            s_div_reg     <= '0;
            s_latch_reg   <= '0;
            gate_reg      <= '0;
            for (int i = 0; i < KEY_DEPTH; i++)
            begin
                key_reg[i] <= '0;
            end
            kcnt_reg      <= '0;
            seq_idx_reg   <= '0;
            for (int i = 0; i < pcio_pkg::SEQ_NUM; i++)
            begin
                seq_reg[i] <= '0;
            end
            gr_idx_reg    <= '0;
            for (int i = 0; i < pcio_pkg::GR_NUM; i++)
            begin
                gr_reg[i] <= '0;
            end
            color_reg     <= '0;
            crtc_idx_reg  <= '0;
            offset_reg    <= '0;
            blink_reg     <= 1'b1;
        end
        else
        begin
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg.valid)
            begin
                text_mode_reg <= cfg.text_mode;
            end
            if (fire)
            begin
                t_high_reg   <= t_high_next;
                t_mode_reg   <= t_mode_next;
                t_div_reg    <= t_div_next;
                t_latch_reg  <= t_latch_next;
                s_high_reg   <= s_high_next;
                s_mode_reg   <= s_mode_next;
                s_div_reg    <= s_div_next;
                s_latch_reg  <= s_latch_next;
                gate_reg     <= gate_next;
                key_reg      <= key_next;
                kcnt_reg     <= kcnt_next;
                seq_idx_reg  <= seq_idx_next;
                seq_reg      <= seq_next;
                gr_idx_reg   <= gr_idx_next;
                gr_reg       <= gr_next;
                color_reg    <= color_next;
                crtc_idx_reg <= crtc_idx_next;
                offset_reg   <= offset_next;
                blink_reg    <= blink_next;
            end
        end
    end

    // ---------------- result register ----------------
    // Value outputs come straight from the state: it only changes when a new
    // item loads this register, so they always match the item on show.
    logic [7:0] rd_reg;
    logic       t_reload_reg, s_update_reg, c_load_reg, g_update_reg, k_irq_reg;

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rd_reg       <= rd;
            t_reload_reg <= t_reload;
            s_update_reg <= s_update;
            c_load_reg   <= c_load;
            g_update_reg <= g_update;
            k_irq_reg    <= k_irq;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.read_data      = rd_reg;
    assign rsp.timer_reload   = t_reload_reg;
    assign rsp.timer_divisor  = t_div_reg;
    assign rsp.sound_update   = s_update_reg;
    assign rsp.sound_divisor  = s_div_reg;
    assign rsp.counter_load   = c_load_reg;
    assign rsp.counter_value  = s_latch_reg;
    assign rsp.gate_update    = g_update_reg;
    assign rsp.speaker_gate   = gate_reg;
    assign rsp.key_irq        = k_irq_reg;
    assign rsp.display_offset = offset_reg;
    assign rsp.text_blink     = blink_reg;

endmodule

// File: tb/sv/pc_io_port_decoder_checker.sv
`timescale 1ns / 1ps
// Result checker for the PC I/O port decoder: watches the request, result and
// config channels, predicts each result and compares it field by field.
// Depends on pcio_pkg and the channel interfaces in pcio_if.sv.
module pc_io_port_decoder_checker #(
    parameter int KEY_DEPTH = 4
) (
    input  logic clk,
    input  logic rst_n,
    pcio_req_if  req,
    pcio_rsp_if  rsp,
    pcio_cfg_if  cfg,
    output int   fail_count,
    output int   pending
);

    typedef struct packed {
        logic [7:0]  read_data;
        logic        timer_reload;
        logic [15:0] timer_divisor;
        logic        sound_update;
        logic [15:0] sound_divisor;
        logic        counter_load;
        logic [15:0] counter_value;
        logic        gate_update;
        logic [7:0]  speaker_gate;
        logic        key_irq;
        logic [16:0] display_offset;
        logic        text_blink;
    } port_result_t;

    // bits kept per sequencer / graphics register
    localparam logic [7:0] SEQ_KEEP [0:4] = '{8'h03, 8'h3F, 8'h0F, 8'h7F, 8'h0F};
    localparam logic [7:0] GR_KEEP  [0:8] = '{8'h0F, 8'h0F, 8'h0F, 8'h3F, 8'h03,
                                              8'h7F, 8'h0F, 8'h0F, 8'hFF};

    // shadow of the decoder state
    logic        text_mode;
    logic        timer_high;
    logic [7:0]  timer_mode;
    logic [15:0] timer_div;
    logic [15:0] timer_latch;
    logic        sound_high;
    logic [7:0]  sound_mode;
    logic [15:0] sound_div;
    logic [15:0] sound_latch;
    logic [7:0]  gate_byte;
    logic [7:0]  key_queue [KEY_DEPTH];
    int          key_count;
    logic [2:0]  seq_index;
    logic [7:0]  seq_regs [pcio_pkg::SEQ_NUM];
    logic [3:0]  gr_index;
    logic [7:0]  gr_regs [pcio_pkg::GR_NUM];
    logic [7:0]  color_byte;
    logic [7:0]  crtc_index;
    logic [16:0] start_offset;
    logic        blink_on;

    port_result_t expected_results [$];
    int           errors = 0;

    function automatic port_result_t decode_access(input logic [1:0] op,
                                                   input logic [15:0] addr,
                                                   input logic [7:0] data,
                                                   input logic [15:0] now,
                                                   input logic [15:0] scount,
                                                   input logic vs);
        port_result_t   r;
        pcio_pkg::acc_t acc;
        int             i;
        r = '0;
        r.read_data = pcio_pkg::BYTE_ONES;
        if (op == pcio_pkg::CMD_READ)
        begin
            case (addr)
                pcio_pkg::PORT_TIMER0:
                begin
                    if (timer_high)
                    begin
                        timer_high = 1'b0;
                        r.read_data = timer_latch[15:8];
                    end
                    else
                    begin
                        timer_latch = now;
                        timer_high = 1'b1;
                        r.read_data = now[7:0];
                    end
                end
                pcio_pkg::PORT_TIMER2:
                begin
                    acc = pcio_pkg::acc_t'(sound_mode[5:4]);
                    case (acc)
                        pcio_pkg::ACC_WORD:
                        begin
                            r.read_data = sound_high ? sound_div[15:8] : sound_div[7:0];
                            sound_high = ~sound_high;
                        end
                        pcio_pkg::ACC_LOW:  r.read_data = sound_div[7:0];
                        pcio_pkg::ACC_HIGH: r.read_data = sound_div[15:8];
                        default:
                        begin
                            if (sound_high)
                            begin
                                sound_high = 1'b0;
                                r.read_data = sound_latch[15:8];
                            end
                            else
                            begin
                                sound_latch = scount;
                                sound_high = 1'b1;
                                r.read_data = scount[7:0];
                            end
                        end
                    endcase
                end
                pcio_pkg::PORT_MODE:     r.read_data = sound_mode;
                pcio_pkg::PORT_KBD_DATA:
                begin
                    r.read_data = key_queue[0];
                    if (key_count > 1)
                    begin
                        for (i = 0; i < KEY_DEPTH - 1; i++)
                            key_queue[i] = key_queue[i + 1];
                        r.key_irq = 1'b1;
                    end
                    if (key_count > 0)
                        key_count--;
                end
                pcio_pkg::PORT_GATE:     r.read_data = gate_byte;
                pcio_pkg::PORT_KBD_STAT: r.read_data = (key_count > 0) ? 8'd1 : 8'd0;
                pcio_pkg::PORT_SEQ_IDX:  r.read_data = {5'd0, seq_index};
                pcio_pkg::PORT_SEQ_DAT:
                    r.read_data = (seq_index < pcio_pkg::SEQ_NUM) ? seq_regs[seq_index] : 8'd0;
                pcio_pkg::PORT_GR_IDX:   r.read_data = {4'd0, gr_index};
                pcio_pkg::PORT_GR_DAT:
                    r.read_data = (gr_index < pcio_pkg::GR_NUM) ? gr_regs[gr_index] : 8'd0;
                pcio_pkg::PORT_COLOR:    r.read_data = color_byte;
                pcio_pkg::PORT_STATUS:   r.read_data = vs ? pcio_pkg::VSYNC_BIT : 8'd0;
                default:       ;
            endcase
        end
        else if (op == pcio_pkg::CMD_WRITE)
        begin
            case (addr)
                pcio_pkg::PORT_TIMER0:
                begin
                    acc = pcio_pkg::acc_t'(timer_mode[5:4]);
                    case (acc)
                        pcio_pkg::ACC_WORD:
                        begin
                            if (timer_high)
                            begin
                                timer_div[15:8] = data;
                                timer_high = 1'b0;
                                r.timer_reload = 1'b1;
                            end
                            else
                            begin
                                timer_div[7:0] = data;
                                timer_high = 1'b1;
                            end
                        end
                        pcio_pkg::ACC_LOW:
                        begin
                            timer_div[7:0] = data;
                            r.timer_reload = 1'b1;
                        end
                        pcio_pkg::ACC_HIGH:
                        begin
                            timer_div[15:8] = data;
                            r.timer_reload = 1'b1;
                        end
                        default: ;
                    endcase
                end
                pcio_pkg::PORT_TIMER2:
                begin
                    acc = pcio_pkg::acc_t'(sound_mode[5:4]);
                    case (acc)
                        pcio_pkg::ACC_WORD:
                        begin
                            if (sound_high)
                            begin
                                sound_div[15:8] = data;
                                sound_high = 1'b0;
                                r.sound_update = 1'b1;
                            end
                            else
                            begin
                                sound_div[7:0] = data;
                                sound_high = 1'b1;
                            end
                        end
                        pcio_pkg::ACC_LOW:
                        begin
                            sound_div[7:0] = data;
                            r.sound_update = 1'b1;
                        end
                        pcio_pkg::ACC_HIGH:
                        begin
                            sound_div[15:8] = data;
                            r.sound_update = 1'b1;
                        end
                        default:
                        begin
                            if (sound_high)
                            begin
                                sound_latch[15:8] = data;
                                sound_high = 1'b0;
                                r.counter_load = 1'b1;
                            end
                            else
                            begin
                                sound_latch[7:0] = data;
                                sound_high = 1'b1;
                            end
                        end
                    endcase
                end
                pcio_pkg::PORT_MODE:
                begin
                    if (data[7:6] == pcio_pkg::SEL_CH0)
                    begin
                        timer_mode = data;
                        timer_high = 1'b0;
                    end
                    else if (data[7:6] == pcio_pkg::SEL_CH2)
                    begin
                        sound_high = 1'b0;
                        if (data != sound_mode)
                        begin
                            sound_mode = data;
                            r.sound_update = 1'b1;
                        end
                    end
                end
                pcio_pkg::PORT_GATE:
                begin
                    gate_byte = data;
                    r.gate_update = 1'b1;
                end
                pcio_pkg::PORT_SEQ_IDX: seq_index = data[2:0];
                pcio_pkg::PORT_SEQ_DAT:
                    if (seq_index < pcio_pkg::SEQ_NUM)
                        seq_regs[seq_index] = data & SEQ_KEEP[seq_index];
                pcio_pkg::PORT_GR_IDX:  gr_index = data[3:0];
                pcio_pkg::PORT_GR_DAT:
                    if (gr_index < pcio_pkg::GR_NUM)
                        gr_regs[gr_index] = data & GR_KEEP[gr_index];
                pcio_pkg::PORT_COLOR:
                begin
                    color_byte = data;
                    blink_on = ~data[4];
                end
                pcio_pkg::PORT_MDA_IDX, pcio_pkg::PORT_CGA_IDX: crtc_index = data;
                pcio_pkg::PORT_MDA_DAT, pcio_pkg::PORT_CGA_DAT:
                begin
                    // text mode uses word addressing: offset is scaled by two
                    if (crtc_index == pcio_pkg::CRTC_START_HI)
                        start_offset = text_mode ? {data, start_offset[8:0]}
                                                 : {1'b0, data, start_offset[7:0]};
                    else if (crtc_index == pcio_pkg::CRTC_START_LO)
                        start_offset = text_mode ? {start_offset[16:9], data, 1'b0}
                                                 : {1'b0, start_offset[15:8], data};
                end
                default: ;
            endcase
        end
        else if (op == pcio_pkg::CMD_KEY)
        begin
            if (key_count < KEY_DEPTH)
            begin
                if (key_count == 0)
                    r.key_irq = 1'b1;
                key_queue[key_count] = data;
                key_count++;
            end
        end
        r.timer_divisor  = timer_div;
        r.sound_divisor  = sound_div;
        r.counter_value  = sound_latch;
        r.speaker_gate   = gate_byte;
        r.display_offset = start_offset;
        r.text_blink     = blink_on;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [16:0] want,
                                        input logic [16:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        port_result_t want;
        if (!rst_n)
        begin
            text_mode    = 1'b1;
            timer_high   = 1'b0;
            timer_mode   = '0;
            timer_div    = '0;
            timer_latch  = '0;
            sound_high   = 1'b0;
            sound_mode   = '0;
            sound_div    = '0;
            sound_latch  = '0;
            gate_byte    = '0;
            key_count    = 0;
            seq_index    = '0;
            gr_index     = '0;
            color_byte   = '0;
            crtc_index   = '0;
            start_offset = '0;
            blink_on     = 1'b1;
            foreach (key_queue[k]) key_queue[k] = '0;
            foreach (seq_regs[k]) seq_regs[k] = '0;
            foreach (gr_regs[k]) gr_regs[k] = '0;
            expected_results.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                text_mode = cfg.text_mode;
            if (req.valid && req.ready)
                expected_results.push_back(decode_access(req.cmd, req.port_addr,
                                                         req.write_data, req.timer_now,
                                                         req.sound_count, req.vsync));
            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with no item outstanding, expected none actual %0h",
                             $time, rsp.read_data);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("read_data", 17'(want.read_data), 17'(rsp.read_data));
                    check_field("timer_reload", 17'(want.timer_reload),
                                17'(rsp.timer_reload));
                    check_field("timer_divisor", 17'(want.timer_divisor),
                                17'(rsp.timer_divisor));
                    check_field("sound_update", 17'(want.sound_update),
                                17'(rsp.sound_update));
                    check_field("sound_divisor", 17'(want.sound_divisor),
                                17'(rsp.sound_divisor));
                    check_field("counter_load", 17'(want.counter_load),
                                17'(rsp.counter_load));
                    check_field("counter_value", 17'(want.counter_value),
                                17'(rsp.counter_value));
                    check_field("gate_update", 17'(want.gate_update), 17'(rsp.gate_update));
                    check_field("speaker_gate", 17'(want.speaker_gate),
                                17'(rsp.speaker_gate));
                    check_field("key_irq", 17'(want.key_irq), 17'(rsp.key_irq));
                    check_field("display_offset", want.display_offset, rsp.display_offset);
                    check_field("text_blink", 17'(want.text_blink), 17'(rsp.text_blink));
                end
            end
        end
        pending    <= expected_results.size();
        fail_count <= errors;
    end

endmodule

// File: tb/sv/pc_io_port_decoder_test.sv
`timescale 1ns / 1ps
// Top of the PC I/O port decoder testbench: clock, reset, stimulus, receiver
// stalls, watchdog and verdict. Depends on pcio_pkg, pcio_if.sv, the decoder
// and pc_io_port_decoder_checker.
module pc_io_port_decoder_test;

    localparam int KEY_DEPTH      = 4;
    localparam int PHASE_ITEMS    = 250;   // random items per text-mode phase
    localparam int SETTLE_CYCLES  = 4;     // request-to-result latency plus margin
    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no item accepted anywhere

    logic clk;
    logic rst_n;

    pcio_req_if req_ch ();
    pcio_rsp_if rsp_ch ();
    pcio_cfg_if cfg_ch ();

    int fail_count;
    int pending;

    int items_sent;
    int burst_left;
    int idle_cycles = 0;

    // receiver stall pattern state
    int stall_style = 0;
    int stall_span  = 0;
    int stall_tick  = 0;

    pc_io_port_decoder #(
        .KEY_DEPTH (KEY_DEPTH)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    pc_io_port_decoder_checker #(
        .KEY_DEPTH (KEY_DEPTH)
    ) u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .cfg        (cfg_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Receiver: every so often picks a new stall style - always ready,
    // random stalls, or a fixed 3-in-8 stall pattern.
    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 1;
        if (stall_span == 0)
        begin
            stall_style <= $urandom_range(0, 2);
            stall_span  <= $urandom_range(16, 96);
        end
        else
            stall_span <= stall_span - 1;
        case (stall_style)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= ($urandom_range(0, 9) < 7);
            default: rsp_ch.ready <= ((stall_tick % 8) >= 3);
        endcase
    end

    // Watchdog: any accepted item on any channel restarts the count.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("pc_io_port_decoder verification failed");
            $finish;
        end
    end

    // One request item. The sender runs in bursts; between bursts valid
    // drops for a random gap. Here valid is only lowered when a gap starts, so a
    // back-to-back item never sees valid go low and high in one step.
    task automatic send_item(input logic [1:0] op, input logic [15:0] addr,
                             input logic [7:0] data);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        req_ch.valid       <= 1'b1;
        req_ch.cmd         <= op;
        req_ch.port_addr   <= addr;
        req_ch.write_data  <= data;
        req_ch.timer_now   <= 16'($urandom);
        req_ch.sound_count <= 16'($urandom);
        req_ch.vsync       <= 1'($urandom_range(0, 1));
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        burst_left--;
        items_sent++;
    endtask

    // Hold off the sender until every result is back, then let the pipe settle.
    // The first edge lets the outstanding count take in the last item sent.
    task automatic drain_results;
        req_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_text_mode(input logic mode);
        cfg_ch.text_mode <= mode;
        cfg_ch.valid     <= 1'b1;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [1:0] read_or_write();
        return $urandom_range(0, 1) ? pcio_pkg::CMD_WRITE : pcio_pkg::CMD_READ;
    endfunction

    task automatic run_directed;
        // timer read latch and flip-flop, speaker counter latch in access mode 0
        send_item(pcio_pkg::CMD_READ, pcio_pkg::PORT_TIMER0, 8'h00);
        send_item(pcio_pkg::CMD_READ, pcio_pkg::PORT_TIMER0, 8'h00);
        send_item(pcio_pkg::CMD_READ, pcio_pkg::PORT_TIMER2, 8'h00);
        send_item(pcio_pkg::CMD_READ, pcio_pkg::PORT_TIMER2, 8'h00);
        // timer data write while access mode is still 0: dropped
        send_item(pcio_pkg::CMD_WRITE, pcio_pkg::PORT_TIMER0, 8'hFF);
        // channel 0 word access, then low and high byte
        send_item(pcio_pkg::CMD_WRITE, pcio_pkg::PORT_MODE,
                  {pcio_pkg::SEL_CH0, pcio_pkg::ACC_WORD, 4'h0});
        send_item(pcio_pkg::CMD_WRITE, pcio_pkg::PORT_TIMER0, 8'h00);
        send_item(pcio_pkg::CMD_WRITE, pcio_pkg::PORT_TIMER0, 8'hFF);
        // channel 2 word access, divisor, mode read back
        send_item(pcio_pkg::CMD_WRITE, pcio_pkg::PORT_MODE,
                  {pcio_pkg::SEL_CH2, pcio_pkg::ACC_WORD, 4'hF});
        send_item(pcio_pkg::CMD_WRITE, pcio_pkg::PORT_TIMER2, 8'hFF);
        send_item(pcio_pkg::CMD_WRITE, pcio_pkg::PORT_TIMER2, 8'h00);
        send_item(pcio_pkg::CMD_READ, pcio_pkg::PORT_MODE, 8'h00);
        // select fields 1 and 3 are ignored
        send_item(pcio_pkg::CMD_WRITE, pcio_pkg::PORT_MODE, 8'h70);
        send_item(pcio_pkg::CMD_WRITE, pcio_pkg::PORT_MODE, 8'hFF);
        // empty queue read, then fill past the depth and drain a little
        send_item(pcio_pkg::CMD_READ, pcio_pkg::PORT_KBD_DATA, 8'h00);
        repeat (KEY_DEPTH + 1) send_item(pcio_pkg::CMD_KEY, 16'h0000, 8'($urandom));
        send_item(pcio_pkg::CMD_READ, pcio_pkg::PORT_KBD_STAT, 8'h00);
        send_item(pcio_pkg::CMD_READ, pcio_pkg::PORT_KBD_DATA, 8'h00);
        // EGA data ports with the index out of range
        send_item(pcio_pkg::CMD_WRITE, pcio_pkg::PORT_SEQ_IDX, 8'hFF);
        send_item(pcio_pkg::CMD_WRITE, pcio_pkg::PORT_SEQ_DAT, 8'hFF);
        send_item(pcio_pkg::CMD_READ, pcio_pkg::PORT_SEQ_DAT, 8'h00);
        send_item(pcio_pkg::CMD_WRITE, pcio_pkg::PORT_GR_IDX, 8'hFF);
        send_item(pcio_pkg::CMD_READ, pcio_pkg::PORT_GR_DAT, 8'h00);
        // colour select blink bit, text-mode CRTC start offset
        send_item(pcio_pkg::CMD_WRITE, pcio_pkg::PORT_COLOR, 8'hFF);
        send_item(pcio_pkg::CMD_WRITE, pcio_pkg::PORT_CGA_IDX, pcio_pkg::CRTC_START_HI);
        send_item(pcio_pkg::CMD_WRITE, pcio_pkg::PORT_CGA_DAT, 8'hFF);
        send_item(pcio_pkg::CMD_WRITE, pcio_pkg::PORT_MDA_IDX, pcio_pkg::CRTC_START_LO);
        send_item(pcio_pkg::CMD_WRITE, pcio_pkg::PORT_MDA_DAT, 8'hFF);
        // gate port, unused command, odd ports
        send_item(pcio_pkg::CMD_WRITE, pcio_pkg::PORT_GATE, 8'hFF);
        send_item(pcio_pkg::CMD_UNUSED, pcio_pkg::PORT_GATE, 8'h00);
        send_item(pcio_pkg::CMD_READ, 16'h03C0, 8'h00);
        send_item(pcio_pkg::CMD_WRITE, 16'hFFFF, 8'h00);
    endtask

    // One short, mostly well-formed access sequence with random content.
    task automatic random_sequence;
        int         kind;
        int         n;
        logic [1:0] sel;
        kind = $urandom_range(0, 11);
        case (kind)
            0, 1:
            begin
                // channel 0: mode byte, then a few data accesses
                sel = ($urandom_range(0, 7) == 0) ? 2'($urandom) : pcio_pkg::SEL_CH0;
                send_item(pcio_pkg::CMD_WRITE, pcio_pkg::PORT_MODE, {sel, 6'($urandom)});
                n = $urandom_range(1, 4);
                repeat (n) send_item(read_or_write(), pcio_pkg::PORT_TIMER0, 8'($urandom));
            end
            2, 3:
            begin
                sel = ($urandom_range(0, 7) == 0) ? 2'($urandom) : pcio_pkg::SEL_CH2;
                send_item(pcio_pkg::CMD_WRITE, pcio_pkg::PORT_MODE, {sel, 6'($urandom)});
                n = $urandom_range(1, 4);
                repeat (n) send_item(read_or_write(), pcio_pkg::PORT_TIMER2, 8'($urandom));
            end
            4, 5:
            begin
                // keyboard traffic: arrivals mixed with data and status reads
                n = $urandom_range(1, 6);
                repeat (n)
                begin
                    case ($urandom_range(0, 3))
                        0, 1:
                            send_item(pcio_pkg::CMD_KEY, 16'($urandom), 8'($urandom));
                        2:
                            send_item(pcio_pkg::CMD_READ, pcio_pkg::PORT_KBD_DATA,
                                      8'($urandom));
                        default:
                            send_item(pcio_pkg::CMD_READ, pcio_pkg::PORT_KBD_STAT,
                                      8'($urandom));
                    endcase
                end
            end
            6:
            begin
                send_item(read_or_write(), pcio_pkg::PORT_SEQ_IDX, 8'($urandom));
                send_item(read_or_write(), pcio_pkg::PORT_SEQ_DAT, 8'($urandom));
            end
            7:
            begin
                send_item(read_or_write(), pcio_pkg::PORT_GR_IDX, 8'($urandom));
                send_item(read_or_write(), pcio_pkg::PORT_GR_DAT, 8'($urandom));
            end
            8:
            begin
                // CRTC: mostly the start-offset registers, via either port pair
                case ($urandom_range(0, 2))
                    0:
                        send_item(pcio_pkg::CMD_WRITE,
                                  $urandom_range(0, 1) ? pcio_pkg::PORT_MDA_IDX
                                                       : pcio_pkg::PORT_CGA_IDX,
                                  pcio_pkg::CRTC_START_HI);
                    1:
                        send_item(pcio_pkg::CMD_WRITE,
                                  $urandom_range(0, 1) ? pcio_pkg::PORT_MDA_IDX
                                                       : pcio_pkg::PORT_CGA_IDX,
                                  pcio_pkg::CRTC_START_LO);
                    default:
                        send_item(pcio_pkg::CMD_WRITE, pcio_pkg::PORT_CGA_IDX,
                                  8'($urandom));
                endcase
                send_item(read_or_write(),
                          $urandom_range(0, 1) ? pcio_pkg::PORT_MDA_DAT
                                               : pcio_pkg::PORT_CGA_DAT,
                          8'($urandom));
            end
            9:
            begin
                case ($urandom_range(0, 3))
                    0:       send_item(read_or_write(), pcio_pkg::PORT_GATE, 8'($urandom));
                    1:       send_item(read_or_write(), pcio_pkg::PORT_COLOR, 8'($urandom));
                    2:       send_item(pcio_pkg::CMD_READ, pcio_pkg::PORT_STATUS,
                                       8'($urandom));
                    default: send_item(read_or_write(), pcio_pkg::PORT_MODE, 8'($urandom));
                endcase
            end
            10:
                // rest of the 0x3C0 block
                send_item(2'($urandom_range(0, 3)), 16'h03C0 + 16'($urandom_range(0, 15)),
                          8'($urandom));
            default:
                // noise: any command, any port
                send_item(2'($urandom_range(0, 3)), 16'($urandom), 8'($urandom));
        endcase
    endtask

    initial
    begin
        int phase;
        int target;
        clk         = 1'b0;
        rst_n       = 1'b0;
        items_sent  = 0;
        burst_left  = 0;

        req_ch.valid       <= 1'b0;
        req_ch.cmd         <= pcio_pkg::CMD_READ;
        req_ch.port_addr   <= '0;
        req_ch.write_data  <= '0;
        req_ch.timer_now   <= '0;
        req_ch.sound_count <= '0;
        req_ch.vsync       <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.text_mode   <= 1'b1;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part runs in the reset video class (text)
        run_directed();

        // random phases, text mode alternating 0 / 1 / 0 / 1 / 0;
        // each phase boundary is a full drain of the result channel
        for (phase = 0; phase < 5; phase++)
        begin
            drain_results();
            write_text_mode(phase % 2 == 1);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
                random_sequence();
        end

        drain_results();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("pc_io_port_decoder verification clean");
        else
            $display("pc_io_port_decoder verification failed");
        $finish;
    end

endmodule
